// ===== hdl/rpps_pkg.sv =====
// shared types and codes for the render phase priority scheduler
`default_nettype none

package rpps_pkg;

   localparam int OP_W     = 3;
   localparam int REGION_W = 8;
   localparam int PHASE_W  = 4;

   localparam int REGION_STATUS_BIT  = 0;
   localparam int REGION_READING_BIT = 1;

   typedef enum logic [OP_W-1:0] {
      OP_REQ_REGIONS = 3'd0,
      OP_REQ_TREND   = 3'd1,
      OP_KICK        = 3'd2,
      OP_YIELD       = 3'd3,
      OP_COMPLETE    = 3'd4,
      OP_TAKE_EDGE   = 3'd5
   } op_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_INIT_STATUS  = 4'd0,
      PH_INIT_READING = 4'd1,
      PH_INIT_STATIC  = 4'd2,
      PH_INIT_COLUMNS = 4'd3,
      PH_IDLE         = 4'd4,
      PH_STATUS       = 4'd5,
      PH_READING      = 4'd6,
      PH_AXES         = 4'd7,
      PH_COLUMNS      = 4'd8
   } phase_type;

   typedef struct packed {
      op_type              op;
      logic [REGION_W-1:0] regions;
   } req_item_type;

   typedef struct packed {
      phase_type           phase;
      logic [REGION_W-1:0] pending_mask;
      logic                trend_waiting;
      logic                yielded;
      logic                initial_edge;
      logic                initial_done;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== hdl/rpps_if.sv =====
// request and response channel interfaces
`default_nettype none

interface rpps_req_if;
   logic                         valid;
   logic                         ready;
   logic [rpps_pkg::OP_W-1:0]     op;
   logic [rpps_pkg::REGION_W-1:0] regions;

   modport source (output valid, output op, output regions, input ready);
   modport sink   (input valid, input op, input regions, output ready);
endinterface

interface rpps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rpps_pkg::PHASE_W-1:0]  phase;
   logic [rpps_pkg::REGION_W-1:0] pending_mask;
   logic                          trend_waiting;
   logic                          yielded;
   logic                          initial_edge;
   logic                          initial_done;

   modport source (output valid, output phase, output pending_mask, output trend_waiting,
                   output yielded, output initial_edge, output initial_done, input ready);
   modport sink   (input valid, input phase, input pending_mask, input trend_waiting,
                   input yielded, input initial_edge, input initial_done, output ready);
endinterface

`default_nettype wire

// ===== hdl/rpps_in_stage.sv =====
// input register for one request transaction
`default_nettype none

module rpps_in_stage (
   input  wire logic          clock,
   input  wire logic          reset,
   rpps_req_if.sink           req_ch,
   input  wire logic          take,
   output rpps_pkg::req_item_type item,
   output logic               item_valid
);
   import rpps_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         load;

   // slot frees when the scheduler consumes the held transaction
   assign req_ch.ready = !valid_ff || take;
   assign load         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in        = 1'b1;
         item_in.op      = op_type'(req_ch.op);
         item_in.regions = req_ch.regions;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

`default_nettype wire

// ===== hdl/rpps_sched.sv =====
// scheduler state, next-phase selection and result register
`default_nettype none

module rpps_sched (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rpps_pkg::req_item_type item,
   input  wire logic                   item_valid,
   output logic                        take,
   rpps_rsp_if.source                  rsp_ch
);
   import rpps_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [REGION_W-1:0] pend_ff, pend_in;
   logic                trend_ff, trend_in;
   logic                resume_ff, resume_in;
   logic                done_ff, done_in;
   logic                edge_ff, edge_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_ff, rsp_in;
   logic                yielded, edge_out, do_pick, step;

   // consume when the result register is empty or being drained
   assign step = item_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign take = step;

   always_comb begin
      phase_in  = phase_ff;
      pend_in   = pend_ff;
      trend_in  = trend_ff;
      resume_in = resume_ff;
      done_in   = done_ff;
      edge_in   = edge_ff;
      yielded   = 1'b0;
      edge_out  = 1'b0;
      do_pick   = 1'b0;

      case (item.op)
         OP_REQ_REGIONS: begin
            pend_in = pend_ff | item.regions;
            do_pick = (phase_ff == PH_IDLE);
         end
         OP_REQ_TREND: begin
            trend_in = 1'b1;
         end
         OP_KICK: begin
            do_pick = (phase_ff == PH_IDLE);
         end
         OP_YIELD: begin
            if ((phase_ff inside {PH_AXES, PH_COLUMNS}) && (pend_ff != '0)) begin
               trend_in = 1'b1;
               do_pick  = 1'b1;
               yielded  = 1'b1;
            end
         end
         OP_COMPLETE: begin
            case (phase_ff)
               PH_INIT_STATUS:  phase_in = PH_INIT_READING;
               PH_INIT_READING: phase_in = PH_INIT_STATIC;
               PH_INIT_STATIC:  phase_in = PH_INIT_COLUMNS;
               PH_INIT_COLUMNS: begin
                  done_in = 1'b1;
                  edge_in = 1'b1;
                  do_pick = 1'b1;
               end
               PH_AXES: begin
                  resume_in = 1'b1;
                  phase_in  = PH_COLUMNS;
               end
               PH_COLUMNS: begin
                  resume_in = 1'b0;
                  do_pick   = 1'b1;
               end
               default: do_pick = 1'b1;
            endcase
         end
         OP_TAKE_EDGE: begin
            edge_out = edge_ff;
            edge_in  = 1'b0;
         end
         default: ;
      endcase

      // strict priority: status, reading, then trend
      if (do_pick) begin
         if (pend_in[REGION_STATUS_BIT]) begin
            pend_in[REGION_STATUS_BIT] = 1'b0;
            phase_in = PH_STATUS;
         end else if (pend_in[REGION_READING_BIT]) begin
            pend_in[REGION_READING_BIT] = 1'b0;
            phase_in = PH_READING;
         end else if (trend_in) begin
            trend_in = 1'b0;
            phase_in = resume_in ? PH_COLUMNS : PH_AXES;
         end else begin
            phase_in = PH_IDLE;
         end
      end

      rsp_in.phase         = phase_in;
      rsp_in.pending_mask  = pend_in;
      rsp_in.trend_waiting = trend_in;
      rsp_in.yielded       = yielded;
      rsp_in.initial_edge  = edge_out;
      rsp_in.initial_done  = done_in;

      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_INIT_STATUS;
         pend_ff      <= '0;
         trend_ff     <= 1'b0;
         resume_ff    <= 1'b0;
         done_ff      <= 1'b0;
         edge_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            phase_ff  <= phase_in;
            pend_ff   <= pend_in;
            trend_ff  <= trend_in;
            resume_ff <= resume_in;
            done_ff   <= done_in;
            edge_ff   <= edge_in;
         end
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.phase         = rsp_ff.phase;
   assign rsp_ch.pending_mask  = rsp_ff.pending_mask;
   assign rsp_ch.trend_waiting = rsp_ff.trend_waiting;
   assign rsp_ch.yielded       = rsp_ff.yielded;
   assign rsp_ch.initial_edge  = rsp_ff.initial_edge;
   assign rsp_ch.initial_done  = rsp_ff.initial_done;

endmodule

`default_nettype wire

// ===== hdl/render_phase_priority_scheduler.sv =====
// top level of the render phase priority scheduler
//
// usage
// - req_ch carries one event per transaction: op (request regions, request
//   trend, kick, yield trend, complete phase, take initial edge) and a
//   dirty region mask used only by request regions
// - rsp_ch returns exactly one transaction per event: the phase after the
//   event, the dirty bits still waiting, the trend pending flag, the yield
//   and initial-edge flags for that event and the start-up done flag
// - an event taken is held in the input register, and its result then sits
//   in the result register
// - throughput: one event per cycle while rsp_ch.ready is high, set by the
//   single register-to-register selection path in the scheduler stage;
//   state advances as each event moves from input to result register
// - reset (synchronous, active high) puts the block in the initial status
//   phase with no pending work and empties both registers
// - a stalled receiver holds the result; one more event waits in the input
//   register and then req_ch.ready drops until the result drains
`default_nettype none

module render_phase_priority_scheduler (
   input wire logic   clock,
   input wire logic   reset,
   rpps_req_if.sink   req_ch,
   rpps_rsp_if.source rsp_ch
);
   import rpps_pkg::*;

   req_item_type item;
   logic         item_valid;
   logic         take;

   // input register, released by the scheduler stage
   rpps_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .take       (take),
      .item       (item),
      .item_valid (item_valid)
   );

   // state update, priority select and result register
   rpps_sched u_sched (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .take       (take),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== hdl/rpps_checker.sv =====
// port-level checks for the render phase priority scheduler, with bind
`default_nettype none

module rpps_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [rpps_pkg::PHASE_W-1:0]  rsp_phase,
   input wire logic [rpps_pkg::REGION_W-1:0] rsp_pending_mask,
   input wire logic rsp_yielded,
   input wire logic rsp_initial_edge,
   input wire logic rsp_initial_done
);
   import rpps_pkg::*;

   // a stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase)
         && $stable(rsp_pending_mask))
      else $error("stalled result changed");

   // the done edge only exists once start-up is over
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_initial_edge |-> rsp_initial_done)
      else $error("initial edge without initial done");

   // trend work, hence a yield, only happens after start-up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_yielded |-> rsp_initial_done)
      else $error("yield during start-up");

   // before start-up ends only the initial phases are shown
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_initial_done |-> (rsp_phase == PH_INIT_STATUS
         || rsp_phase == PH_INIT_READING || rsp_phase == PH_INIT_STATIC
         || rsp_phase == PH_INIT_COLUMNS))
      else $error("non-initial phase before start-up done");

endmodule

bind render_phase_priority_scheduler rpps_checker u_rpps_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_phase        (rsp_ch.phase),
   .rsp_pending_mask (rsp_ch.pending_mask),
   .rsp_yielded      (rsp_ch.yielded),
   .rsp_initial_edge (rsp_ch.initial_edge),
   .rsp_initial_done (rsp_ch.initial_done)
);

`default_nettype wire

// ===== test/render_phase_priority_scheduler_checker.sv =====
// scoreboard for the render phase priority scheduler: predicts and compares every response
`default_nettype none

module render_phase_priority_scheduler_checker (
   input wire logic clock,
   input wire logic reset,
   rpps_req_if      req_mon,
   rpps_rsp_if      rsp_mon,
   output int       pending_results,
   output int       mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rpps_pkg::*;

   // shadow scheduler state
   phase_type           cur_phase;
   logic [REGION_W-1:0] dirty_bits;
   logic                trend_queued;
   logic                resume_at_columns;
   logic                startup_done;
   logic                startup_edge;

   rsp_item_type predicted_rsp_q[$];

   initial mismatch_count = 0;

   function void clear_schedule();
      cur_phase         = PH_INIT_STATUS;
      dirty_bits        = '0;
      trend_queued      = 1'b0;
      resume_at_columns = 1'b0;
      startup_done      = 1'b0;
      startup_edge      = 1'b0;
   endfunction

   // strict priority: status, reading, then trend
   function void select_next_work();
      if (dirty_bits[REGION_STATUS_BIT]) begin
         dirty_bits[REGION_STATUS_BIT] = 1'b0;
         cur_phase = PH_STATUS;
      end else if (dirty_bits[REGION_READING_BIT]) begin
         dirty_bits[REGION_READING_BIT] = 1'b0;
         cur_phase = PH_READING;
      end else if (trend_queued) begin
         trend_queued = 1'b0;
         cur_phase = resume_at_columns ? PH_COLUMNS : PH_AXES;
      end else begin
         cur_phase = PH_IDLE;
      end
   endfunction

   function void finish_current_phase();
      case (cur_phase)
         PH_INIT_STATUS:  cur_phase = PH_INIT_READING;
         PH_INIT_READING: cur_phase = PH_INIT_STATIC;
         PH_INIT_STATIC:  cur_phase = PH_INIT_COLUMNS;
         PH_INIT_COLUMNS: begin
            startup_done = 1'b1;
            startup_edge = 1'b1;
            select_next_work();
         end
         PH_AXES: begin
            resume_at_columns = 1'b1;
            cur_phase = PH_COLUMNS;
         end
         PH_COLUMNS: begin
            resume_at_columns = 1'b0;
            select_next_work();
         end
         default: select_next_work();
      endcase
   endfunction

   function rsp_item_type predict_schedule(input logic [OP_W-1:0] op,
                                           input logic [REGION_W-1:0] regions);
      rsp_item_type outcome;
      logic         did_yield;
      logic         took_edge;
      did_yield = 1'b0;
      took_edge = 1'b0;
      case (op)
         OP_REQ_REGIONS: begin
            dirty_bits = dirty_bits | regions;
            if (cur_phase == PH_IDLE) select_next_work();
         end
         OP_REQ_TREND: trend_queued = 1'b1;
         OP_KICK: if (cur_phase == PH_IDLE) select_next_work();
         OP_YIELD: begin
            if ((cur_phase == PH_AXES || cur_phase == PH_COLUMNS) && dirty_bits != '0) begin
               trend_queued = 1'b1;
               select_next_work();
               did_yield = 1'b1;
            end
         end
         OP_COMPLETE: finish_current_phase();
         OP_TAKE_EDGE: begin
            took_edge = startup_edge;
            startup_edge = 1'b0;
         end
         default: ;
      endcase
      outcome.phase         = cur_phase;
      outcome.pending_mask  = dirty_bits;
      outcome.trend_waiting = trend_queued;
      outcome.yielded       = did_yield;
      outcome.initial_edge  = took_edge;
      outcome.initial_done  = startup_done;
      return outcome;
   endfunction

   task note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t ns: %s", $time, what);
   endtask

   task compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want)
         note_mismatch($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
   endtask

   task check_response();
      rsp_item_type want;
      if (predicted_rsp_q.size() == 0) begin
         note_mismatch("response with no transaction outstanding");
      end else begin
         want = predicted_rsp_q.pop_front();
         compare_field("phase", 8'(want.phase), 8'(rsp_mon.phase));
         compare_field("pending_mask", want.pending_mask, rsp_mon.pending_mask);
         compare_field("trend_waiting", 8'(want.trend_waiting), 8'(rsp_mon.trend_waiting));
         compare_field("yielded", 8'(want.yielded), 8'(rsp_mon.yielded));
         compare_field("initial_edge", 8'(want.initial_edge), 8'(rsp_mon.initial_edge));
         compare_field("initial_done", 8'(want.initial_done), 8'(rsp_mon.initial_done));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_schedule();
         predicted_rsp_q.delete();
         pending_results <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_response();
         if (req_mon.valid && req_mon.ready)
            predicted_rsp_q.push_back(predict_schedule(req_mon.op, req_mon.regions));
         pending_results <= predicted_rsp_q.size();
      end
   end

endmodule

`default_nettype wire

// ===== test/render_phase_priority_scheduler_tb.sv =====
// testbench top for the render phase priority scheduler: stimulus, stalls and verdict
`default_nettype none

module render_phase_priority_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rpps_pkg::*;

   // op codes the block decodes as no-ops
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   localparam int RANDOM_EVENTS = 1025;
   // mask bits above reading are never cleared, so wide masks only come at the end
   localparam int WIDE_TAIL     = 150;
   localparam int CYCLE_LIMIT   = 200000;

   logic clock = 1'b0;
   logic reset;
   int   pending_results;
   int   mismatch_count;
   int   cycle_count;
   logic sender_steady;

   rpps_req_if req_ch ();
   rpps_rsp_if rsp_ch ();

   render_phase_priority_scheduler DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   render_phase_priority_scheduler_checker scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // idle cycles before the next transaction; steady stretches draw none
   function automatic int draw_wait(input logic steady);
      return steady ? 0 : int'($urandom_range(0, 11));
   endfunction

   // offer one event and hold it until the block takes it
   task automatic send_event(input logic [OP_W-1:0] op, input logic [REGION_W-1:0] regions);
      int gap;
      gap = draw_wait(sender_steady);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.op      <= op;
      req_ch.regions <= regions;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // stop sending and wait until every predicted response has been seen
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      // first let the outstanding count, registered from the handshake, catch up
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // weighted toward completions and requests so the scheduler keeps moving
   task automatic send_random_event(input logic wide_masks);
      int                  pick;
      logic [OP_W-1:0]     op;
      logic [REGION_W-1:0] regions;
      pick    = $urandom_range(0, 99);
      regions = REGION_W'($urandom());
      if (pick < 30)      op = OP_COMPLETE;
      else if (pick < 55) begin
         op = OP_REQ_REGIONS;
         if (!wide_masks) regions = REGION_W'($urandom_range(0, 3));
      end
      else if (pick < 68) op = OP_REQ_TREND;
      else if (pick < 80) op = OP_YIELD;
      else if (pick < 88) op = OP_KICK;
      else if (pick < 94) op = OP_TAKE_EDGE;
      else if (pick < 97) op = OP_SPARE_A;
      else                op = OP_SPARE_B;
      send_event(op, regions);
   endtask

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[render_phase_priority_scheduler] ERROR");
      $finish;
   end

   // response side: random stalls after each transaction, with steady stretches
   initial begin
      int   gap;
      int   served;
      logic steady;
      served = 0;
      steady = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            served++;
            if (served % 64 == 0) steady = ($urandom_range(0, 3) == 0);
            gap = draw_wait(steady);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      int counted;
      sender_steady  = 1'b0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.op      <= OP_REQ_REGIONS;
      req_ch.regions <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // start-up sequence with the busy and no-effect cases on the way
      send_event(OP_TAKE_EDGE, 8'h00);    // edge read before start-up is done
      send_event(OP_YIELD, 8'h00);        // yield outside trend work
      send_event(OP_REQ_REGIONS, 8'h01);  // request while busy, only latched
      send_event(OP_KICK, 8'h00);         // kick while busy
      send_event(OP_SPARE_A, 8'hFF);      // unused op codes change nothing
      send_event(OP_SPARE_B, 8'h00);
      repeat (4) send_event(OP_COMPLETE, 8'h00);  // last one sets done and edge, picks status
      send_event(OP_TAKE_EDGE, 8'h00);    // edge seen once
      send_event(OP_TAKE_EDGE, 8'h00);    // then cleared
      send_event(OP_REQ_TREND, 8'h00);
      send_event(OP_COMPLETE, 8'h00);     // status done, trend axes
      send_event(OP_YIELD, 8'h00);        // trend work but nothing dirty
      send_event(OP_REQ_REGIONS, 8'h02);
      send_event(OP_YIELD, 8'h00);        // preempts axes for reading
      send_event(OP_COMPLETE, 8'h00);     // back to axes
      send_event(OP_COMPLETE, 8'h00);     // axes done, columns
      send_event(OP_REQ_REGIONS, 8'h03);
      send_event(OP_YIELD, 8'h00);        // preempts columns for status
      send_event(OP_COMPLETE, 8'h00);     // reading
      send_event(OP_COMPLETE, 8'h00);     // trend resumes at columns
      send_event(OP_COMPLETE, 8'h00);     // columns done, idle
      send_event(OP_KICK, 8'h00);         // kick with nothing waiting
      send_event(OP_REQ_REGIONS, 8'h00);  // empty request while idle
      send_event(OP_REQ_REGIONS, 8'h02);  // request while idle starts at once
      send_event(OP_COMPLETE, 8'h00);

      counted = 0;
      while (counted < RANDOM_EVENTS) begin
         if (counted % 64 == 0) sender_steady = ($urandom_range(0, 3) == 0);
         if (counted > 0 && counted % 256 == 0) wait_for_drain();
         if (counted == RANDOM_EVENTS - WIDE_TAIL) send_event(OP_REQ_REGIONS, 8'hFF);
         send_random_event(counted >= RANDOM_EVENTS - WIDE_TAIL);
         counted++;
      end

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[render_phase_priority_scheduler] OK");
      end else begin
         $display("[render_phase_priority_scheduler] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
